[hw/rtl/kce_pkg.sv]
// ----------------------------------------------------------------------------
// kce_pkg: shared definitions for the keystroke calculator engine
// Key codes, operator codes and key classes used by the engine.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int OUT_W  = 32;   // width of the accumulator and memory fields
    localparam int KEY_W  = 8;    // width of one key character
    localparam int OP_W   = 3;    // width of an operator code
    localparam int KIND_W = 3;    // width of a key class code

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [KIND_W-1:0] kind_t;

    // Operator codes.
    localparam op_t OP_ADD  = 3'd0;
    localparam op_t OP_SUB  = 3'd1;
    localparam op_t OP_MUL  = 3'd2;
    localparam op_t OP_DIV  = 3'd3;
    localparam op_t OP_HOLD = 3'd4;

    // ASCII key codes.
    localparam key_t KEY_0     = 8'h30;
    localparam key_t KEY_9     = 8'h39;
    localparam key_t KEY_PLUS  = 8'h2B;
    localparam key_t KEY_MINUS = 8'h2D;
    localparam key_t KEY_STAR  = 8'h2A;
    localparam key_t KEY_SLASH = 8'h2F;
    localparam key_t KEY_EQUAL = 8'h3D;
    localparam key_t KEY_C     = 8'h43;
    localparam key_t KEY_R     = 8'h52;
    localparam key_t KEY_P     = 8'h50;
    localparam key_t KEY_M     = 8'h4D;
    localparam key_t KEY_S     = 8'h53;

    // Key classes.
    localparam kind_t KIND_DIGIT  = 3'd0;
    localparam kind_t KIND_OPER   = 3'd1;
    localparam kind_t KIND_CLEAR  = 3'd2;
    localparam kind_t KIND_RECALL = 3'd3;
    localparam kind_t KIND_MPLUS  = 3'd4;
    localparam kind_t KIND_MMINUS = 3'd5;
    localparam kind_t KIND_SIGN   = 3'd6;
    localparam kind_t KIND_IGNORE = 3'd7;

endpackage

[hw/rtl/keystroke_calculator_engine_top.sv]
// ----------------------------------------------------------------------------
// keystroke_calculator_engine_top: four-function calculator with memory keys
// Takes one ASCII key per request and returns the accumulator, the memory
// register and two status flags after every key.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Ports                      Contents
// s_        in   s_tvalid/s_tready/s_tdata  key_code in tdata[7:0]
// m_        out  m_tvalid/m_tready/m_tdata  accumulator [31:0], memory [63:32]
//                m_tuser                    divide_by_zero [0], key_ignored [1]
//
// Steps: a digit, C, R, S, an ignored key or an operator inside a run goes
// from IDLE straight to DONE. An operator key that applies an add, subtract
// or hold, a divide by zero, and P or M with such a pending operator pass
// NEG, ARITH and DONE. A pending multiply adds the MUL state and a pending
// divide by a nonzero value the DIV and FIX states; both go through a shift-add
// or restoring divide unit that retires one operand bit per cycle, which sets the worst-case rate.
// Reset: aresetn is synchronous and active low; it clears the accumulator,
// memory, entry, sign parity and operator state (pending operator = add).
// Stalls: one key is processed at a time; a new request is taken while a
// finished result still waits in the output register, and the next result
// waits for that register to drain.
module keystroke_calculator_engine_top
    import kce_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] key_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] accumulator, [63:32] memory_value
    output logic [1:0]  m_tuser     // [0] divide_by_zero, [1] key_ignored
);

    localparam int W     = DATA_WIDTH;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NEG   = 3'd1;
    localparam logic [2:0] ST_ARITH = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIX   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Sign-extend or truncate a working value to the output field width.
    function automatic logic [OUT_W-1:0] to_out(input logic [W-1:0] v);
        logic [OUT_W+W-1:0] ext;
        ext = {{OUT_W{v[W-1]}}, v};
        return ext[OUT_W-1:0];
    endfunction

    // Architectural state.
    logic [2:0]       state_reg, state_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     mem_reg, mem_next;
    logic [W-1:0]     entry_reg, entry_next;
    op_t              pend_op_reg, pend_op_next;
    logic             parity_reg, parity_next;
    logic             prev_op_reg, prev_op_next;

    // Working registers for the serial arithmetic unit.
    kind_t            kind_reg, kind_next;
    op_t              key_op_reg, key_op_next;
    logic [3:0]       digit_reg, digit_next;
    logic [W-1:0]     opa_reg, opa_next;     // multiplicand, or dividend/quotient
    logic [W-1:0]     opb_reg, opb_next;     // entry operand, multiplier or divisor
    logic [W-1:0]     res_reg, res_next;     // product, remainder or final result
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_q_reg, neg_q_next;
    logic             dz_reg, dz_next;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_acc_reg, m_acc_next;
    logic [OUT_W-1:0] m_mem_reg, m_mem_next;
    logic             m_dz_reg, m_dz_next;
    logic             m_ign_reg, m_ign_next;

    logic             accept;
    logic             out_free;
    logic             need_apply;
    kind_t            dec_kind;
    op_t              dec_op;
    logic [W:0]       div_trial;
    logic [W:0]       div_shift;
    logic [W-1:0]     abs_a;
    logic [W-1:0]     abs_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_mem_reg, m_acc_reg};
    assign m_tuser  = {m_ign_reg, m_dz_reg};

    // Classify the incoming key.
    always_comb begin
        dec_op = OP_HOLD;
        if (s_tdata >= KEY_0 && s_tdata <= KEY_9) begin
            dec_kind = KIND_DIGIT;
        end else if (s_tdata == KEY_PLUS) begin
            dec_kind = KIND_OPER;
            dec_op   = OP_ADD;
        end else if (s_tdata == KEY_MINUS) begin
            dec_kind = KIND_OPER;
            dec_op   = OP_SUB;
        end else if (s_tdata == KEY_STAR) begin
            dec_kind = KIND_OPER;
            dec_op   = OP_MUL;
        end else if (s_tdata == KEY_SLASH) begin
            dec_kind = KIND_OPER;
            dec_op   = OP_DIV;
        end else if (s_tdata == KEY_EQUAL) begin
            dec_kind = KIND_OPER;
            dec_op   = OP_HOLD;
        end else if (s_tdata == KEY_C) begin
            dec_kind = KIND_CLEAR;
        end else if (s_tdata == KEY_R) begin
            dec_kind = KIND_RECALL;
        end else if (s_tdata == KEY_P) begin
            dec_kind = KIND_MPLUS;
        end else if (s_tdata == KEY_M) begin
            dec_kind = KIND_MMINUS;
        end else if (s_tdata == KEY_S) begin
            dec_kind = KIND_SIGN;
        end else begin
            dec_kind = KIND_IGNORE;
        end
    end

    // An operator only evaluates when it starts a run; P and M always do.
    assign need_apply = (dec_kind == KIND_OPER && !prev_op_reg) ||
                        dec_kind == KIND_MPLUS || dec_kind == KIND_MMINUS;

    // One restoring-division step: shift in the next dividend bit and try
    // to subtract the divisor.
    assign div_shift = {res_reg, opa_reg[W-1]};
    assign div_trial = div_shift - {1'b0, opb_reg};

    assign abs_a = acc_reg[W-1] ? (W'(0) - acc_reg) : acc_reg;
    assign abs_b = opb_reg[W-1] ? (W'(0) - opb_reg) : opb_reg;

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        mem_next     = mem_reg;
        entry_next   = entry_reg;
        pend_op_next = pend_op_reg;
        parity_next  = parity_reg;
        prev_op_next = prev_op_reg;
        kind_next    = kind_reg;
        key_op_next  = key_op_reg;
        digit_next   = digit_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        neg_q_next   = neg_q_reg;
        dz_next      = dz_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_acc_next   = m_acc_reg;
        m_mem_next   = m_mem_reg;
        m_dz_next    = m_dz_reg;
        m_ign_next   = m_ign_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = dec_kind;
                    key_op_next = dec_op;
                    digit_next  = s_tdata[3:0];
                    dz_next     = 1'b0;
                    state_next  = need_apply ? ST_NEG : ST_DONE;
                end
            end
            ST_NEG: begin
                // The entry operand, negated when S was pressed an odd number of times.
                opb_next   = parity_reg ? (W'(0) - entry_reg) : entry_reg;
                state_next = ST_ARITH;
            end
            ST_ARITH: begin
                cnt_next = '0;
                unique case (pend_op_reg)
                    OP_ADD: begin
                        res_next   = acc_reg + opb_reg;
                        state_next = ST_DONE;
                    end
                    OP_SUB: begin
                        res_next   = acc_reg - opb_reg;
                        state_next = ST_DONE;
                    end
                    OP_MUL: begin
                        res_next   = '0;
                        opa_next   = acc_reg;
                        state_next = ST_MUL;
                    end
                    OP_DIV: begin
                        if (opb_reg == '0) begin
                            res_next   = acc_reg;
                            dz_next    = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            res_next   = '0;
                            opa_next   = abs_a;
                            opb_next   = abs_b;
                            neg_q_next = acc_reg[W-1] ^ opb_reg[W-1];
                            state_next = ST_DIV;
                        end
                    end
                    default: begin
                        res_next   = acc_reg;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MUL: begin
                // Shift-add: one multiplier bit per cycle, product wraps at W bits.
                res_next = opb_reg[0] ? (res_reg + opa_reg) : res_reg;
                opa_next = {opa_reg[W-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                if (!div_trial[W]) begin
                    res_next = div_trial[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b1};
                end else begin
                    res_next = div_shift[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W - 1)) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                // Apply the quotient sign; truncation toward zero follows.
                res_next   = neg_q_reg ? (W'(0) - opa_reg) : opa_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    prev_op_next = 1'b0;
                    unique case (kind_reg)
                        KIND_DIGIT: begin
                            entry_next = (entry_reg << 3) + (entry_reg << 1) +
                                         {{(W-4){1'b0}}, digit_reg};
                        end
                        KIND_OPER: begin
                            if (!prev_op_reg) begin
                                acc_next    = res_reg;
                                parity_next = 1'b0;
                                entry_next  = '0;
                            end
                            pend_op_next = key_op_reg;
                            prev_op_next = 1'b1;
                        end
                        KIND_CLEAR: begin
                            mem_next = '0;
                        end
                        KIND_RECALL: begin
                            acc_next = mem_reg;
                        end
                        KIND_MPLUS, KIND_MMINUS: begin
                            mem_next     = (kind_reg == KIND_MPLUS) ? (mem_reg + res_reg)
                                                                    : (mem_reg - res_reg);
                            acc_next     = '0;
                            entry_next   = '0;
                            parity_next  = 1'b0;
                            pend_op_next = OP_ADD;
                        end
                        KIND_SIGN: begin
                            parity_next = !parity_reg;
                        end
                        default: begin
                        end
                    endcase
                    m_valid_next = 1'b1;
                    m_acc_next   = to_out(acc_next);
                    m_mem_next   = to_out(mem_next);
                    m_dz_next    = dz_reg;
                    m_ign_next   = (kind_reg == KIND_IGNORE);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            mem_reg     <= '0;
            entry_reg   <= '0;
            pend_op_reg <= OP_ADD;
            parity_reg  <= 1'b0;
            prev_op_reg <= 1'b0;
            cnt_reg     <= '0;
            dz_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            mem_reg     <= mem_next;
            entry_reg   <= entry_next;
            pend_op_reg <= pend_op_next;
            parity_reg  <= parity_next;
            prev_op_reg <= prev_op_next;
            cnt_reg     <= cnt_next;
            dz_reg      <= dz_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and output payload.
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        key_op_reg <= key_op_next;
        digit_reg  <= digit_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        res_reg    <= res_next;
        neg_q_reg  <= neg_q_next;
        m_acc_reg  <= m_acc_next;
        m_mem_reg  <= m_mem_next;
        m_dz_reg   <= m_dz_next;
        m_ign_reg  <= m_ign_next;
    end

    // Inside an operator run the entry and the sign parity are always clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        prev_op_reg |-> (entry_reg == '0 && !parity_reg))
        else $error("operator run with a live entry or sign parity");

    // Keys are processed one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second request taken while a key is in progress");

    // A key that raised a divide by zero is never also an ignored key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("divide by zero flagged on an ignored key");

    // A divide by zero can only come from a pending divide.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dz_reg && state_reg != ST_IDLE) |-> pend_op_reg == OP_DIV)
        else $error("divide by zero without a pending divide");

endmodule
